// File: src/tpc_pkg.sv
// ---------------------------------------------------------------------------
// tpc_pkg
// shared types and constants of the triangle plane clipper
// ---------------------------------------------------------------------------
package tpc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] pos_x;
    logic signed [COORD_WIDTH_DEF-1:0] pos_y;
    logic signed [COORD_WIDTH_DEF-1:0] pos_z;
    logic signed [COORD_WIDTH_DEF-1:0] tex_u;
    logic signed [COORD_WIDTH_DEF-1:0] tex_v;
    logic [31:0]                       tri_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] out_x;
    logic signed [COORD_WIDTH_DEF-1:0] out_y;
    logic signed [COORD_WIDTH_DEF-1:0] out_z;
    logic signed [COORD_WIDTH_DEF-1:0] out_u;
    logic signed [COORD_WIDTH_DEF-1:0] out_v;
    logic [31:0]                       out_color;
    logic                              tri_end;
    logic                              run_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIST,
    ST_PLAN,
    ST_DIV,
    ST_INTERP,
    ST_EMIT
  } state_t;

endpackage

// File: src/triangle_plane_clipper.sv
// ---------------------------------------------------------------------------
// triangle_plane_clipper
// clips triangles against one plane, one shared multiplier and divider
// ---------------------------------------------------------------------------
// Vertices come in as three transfers per triangle. The first two are only
// stored. After the third the block drops in_ready and works through the
// triangle with one shared multiply unit: the distance products, then for
// each new vertex a restoring division and the interpolation products.
// Output vertices are then sent one per transfer from an output register.
// Colour is that of vertex 0.
module triangle_plane_clipper #(
  parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tpc_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int CW = tpc_pkg::COORD_WIDTH_DEF;
  localparam int DW = 64;
  localparam int PW = 2*CW + 1;
  localparam logic signed [DW-1:0] LIM = 64'sd1 <<< 60;
  localparam logic [FRAC_BITS-1:0] QMAX = '1;
  localparam int DCW = $clog2(FRAC_BITS + 1);

  // configuration registers
  logic signed [CW-1:0] nx_r, ny_r, nz_r, off_r;

  // held vertices: 3 vertices x 5 coordinates
  logic signed [CW-1:0] pos_r [9];
  logic signed [CW-1:0] tex_r [6];
  logic [31:0]          col_r;
  logic [1:0]           vcnt_r;

  tpc_pkg::state_t st_r;
  logic [3:0]           step_r;       // general step counter
  logic [1:0]           dk_r;         // distance product within a vertex
  logic [1:0]           dv_r;         // vertex whose distance is summed
  logic signed [DW-1:0] acc_r;        // distance accumulator
  logic signed [DW-1:0] d_r [3];      // distances
  logic [2:0]           ins_r;        // inside flags
  logic [1:0]           ia_r, ob_r;   // current edge endpoints
  logic                 edge_r;       // which new vertex is being made
  logic [DW-1:0]        rem_r;
  logic [DW-1:0]        den_r;
  logic [FRAC_BITS-1:0] q_r;
  logic [DCW-1:0]       dcnt_r;
  logic signed [CW-1:0] nva_r [5];    // first new vertex
  logic signed [CW-1:0] nvb_r [5];    // second new vertex
  // emit list: up to six entries, code 0..2 held vertex, 3 new a, 4 new b
  logic [2:0]           list_r [6];
  logic [2:0]           nlist_r;
  logic [2:0]           eidx_r;
  logic                 ovalid_r;
  tpc_pkg::out_item_t   odata_r;

  assign in_ready  = (st_r == tpc_pkg::ST_LOAD) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  wire in_xfer = in_valid && in_ready;

  // ---------------- shared multiply unit: floor(a*b/2^F), saturated
  logic signed [CW:0]   ma;
  logic signed [CW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] psh;
  logic signed [DW-1:0] mres;
  always_comb begin
    prod = ma * mb;
    psh  = prod >>> FRAC_BITS;
    if (psh > PW'(LIM)) mres = LIM;
    else if (psh < -PW'(LIM)) mres = -LIM;
    else mres = DW'(psh);
  end

  function automatic logic signed [CW-1:0] coord(input logic [1:0] v, input logic [2:0] k);
    logic signed [CW-1:0] r;
    r = '0;
    case (k)
      3'd0, 3'd1, 3'd2: r = pos_r[v*3 + k];
      3'd3: r = tex_r[v*2];
      3'd4: r = tex_r[v*2 + 1];
      default: r = '0;
    endcase
    return r;
  endfunction

  // difference kept one bit wider so it never wraps
  logic signed [CW-1:0] ca, cb;
  logic signed [CW:0]   diff;
  always_comb begin
    ca = coord(ia_r, step_r[2:0]);
    cb = coord(ob_r, step_r[2:0]);
    diff = (CW+1)'(cb) - (CW+1)'(ca);
    ma = '0;
    mb = '0;
    if (st_r == tpc_pkg::ST_DIST) begin
      unique case (dk_r)
        2'd0: ma = (CW+1)'(nx_r);
        2'd1: ma = (CW+1)'(ny_r);
        default: ma = (CW+1)'(nz_r);
      endcase
      mb = pos_r[step_r];
    end else begin
      // interpolation: t in Q0.F as a nonnegative operand
      ma = diff;
      mb = CW'({1'b0, q_r});
    end
  end

  // ---------------- planning of edges and emit list
  logic [1:0] i0, i1, o0, o1;
  logic [1:0] nin;
  always_comb begin
    nin = 2'(ins_r[0]) + 2'(ins_r[1]) + 2'(ins_r[2]);
    i0 = 2'd0; i1 = 2'd0; o0 = 2'd0; o1 = 2'd0;
    priority if (ins_r[0]) i0 = 2'd0;
    else if (ins_r[1]) i0 = 2'd1;
    else i0 = 2'd2;
    priority if (ins_r[2]) i1 = 2'd2;
    else if (ins_r[1]) i1 = 2'd1;
    else i1 = 2'd0;
    priority if (!ins_r[0]) o0 = 2'd0;
    else if (!ins_r[1]) o0 = 2'd1;
    else o0 = 2'd2;
    priority if (!ins_r[2]) o1 = 2'd2;
    else if (!ins_r[1]) o1 = 2'd1;
    else o1 = 2'd0;
  end

  logic [DW-1:0] rsh;
  always_comb rsh = rem_r << 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0; ny_r <= '0; nz_r <= 32'sd65536; off_r <= '0;
      vcnt_r <= '0; st_r <= tpc_pkg::ST_LOAD; ovalid_r <= 1'b0;
      step_r <= '0; eidx_r <= '0; nlist_r <= '0; edge_r <= 1'b0; dcnt_r <= '0;
      dk_r <= '0; dv_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tpc_pkg::REG_NORMAL_X: nx_r  <= cfg_data;
          tpc_pkg::REG_NORMAL_Y: ny_r  <= cfg_data;
          tpc_pkg::REG_NORMAL_Z: nz_r  <= cfg_data;
          tpc_pkg::REG_OFFSET:   off_r <= cfg_data;
        endcase
      end
      // the emit state drives the output register itself
      if (ovalid_r && out_ready && st_r != tpc_pkg::ST_EMIT) ovalid_r <= 1'b0;
      unique case (st_r)
        tpc_pkg::ST_LOAD: begin
          if (in_xfer) begin
            pos_r[vcnt_r*3]     <= in_data.pos_x;
            pos_r[vcnt_r*3 + 1] <= in_data.pos_y;
            pos_r[vcnt_r*3 + 2] <= in_data.pos_z;
            tex_r[vcnt_r*2]     <= in_data.tex_u;
            tex_r[vcnt_r*2 + 1] <= in_data.tex_v;
            if (vcnt_r == 2'd0) col_r <= in_data.tri_color;
            if (vcnt_r == 2'd2) begin
              vcnt_r <= '0;
              st_r <= tpc_pkg::ST_DIST;
              step_r <= '0;
              dk_r <= '0;
              dv_r <= '0;
              acc_r <= -DW'(off_r);
            end else begin
              vcnt_r <= vcnt_r + 2'd1;
            end
          end
        end
        tpc_pkg::ST_DIST: begin
          // products summed per vertex, one distance after its x, y and z terms
          if (dk_r == 2'd2) begin
            d_r[dv_r] <= acc_r + mres;
            ins_r[dv_r] <= !((acc_r + mres) < 0);
            acc_r <= -DW'(off_r);
            dk_r <= '0;
            dv_r <= dv_r + 2'd1;
          end else begin
            acc_r <= acc_r + mres;
            dk_r <= dk_r + 2'd1;
          end
          if (step_r == 4'd8) st_r <= tpc_pkg::ST_PLAN;
          step_r <= step_r + 4'd1;
        end
        tpc_pkg::ST_PLAN: begin
          eidx_r <= '0;
          edge_r <= 1'b0;
          if (nin == 2'd3) begin
            list_r[0] <= 3'd0; list_r[1] <= 3'd1; list_r[2] <= 3'd2;
            nlist_r <= 3'd3;
            st_r <= tpc_pkg::ST_EMIT;
          end else if (nin == 2'd0) begin
            st_r <= tpc_pkg::ST_LOAD;
          end else begin
            if (nin == 2'd1) begin
              list_r[0] <= 3'(i0); list_r[1] <= 3'd3; list_r[2] <= 3'd4;
              nlist_r <= 3'd3;
            end else begin
              list_r[0] <= 3'(i0); list_r[1] <= 3'(i1); list_r[2] <= 3'd3;
              list_r[3] <= 3'(i1); list_r[4] <= 3'd4; list_r[5] <= 3'd3;
              nlist_r <= 3'd6;
            end
            ia_r <= i0;
            ob_r <= o0;
            rem_r <= d_r[i0];
            den_r <= d_r[i0] - d_r[o0];
            dcnt_r <= '0;
            q_r <= '0;
            st_r <= tpc_pkg::ST_DIV;
          end
        end
        tpc_pkg::ST_DIV: begin
          if (den_r == '0) begin
            q_r <= QMAX;
            step_r <= '0;
            st_r <= tpc_pkg::ST_INTERP;
          end else begin
            if (rsh >= den_r) begin
              rem_r <= rsh - den_r;
              q_r <= {q_r[FRAC_BITS-2:0], 1'b1};
            end else begin
              rem_r <= rsh;
              q_r <= {q_r[FRAC_BITS-2:0], 1'b0};
            end
            if (dcnt_r == DCW'(FRAC_BITS - 1)) begin
              step_r <= '0;
              st_r <= tpc_pkg::ST_INTERP;
            end
            dcnt_r <= dcnt_r + 1'b1;
          end
        end
        tpc_pkg::ST_INTERP: begin
          if (!edge_r) nva_r[step_r[2:0]] <= CW'(DW'(ca) + mres);
          else         nvb_r[step_r[2:0]] <= CW'(DW'(ca) + mres);
          step_r <= step_r + 4'd1;
          if (step_r == 4'd4) begin
            if (edge_r) begin
              st_r <= tpc_pkg::ST_EMIT;
            end else begin
              edge_r <= 1'b1;
              // second edge: one inside uses i0-o1, two inside uses i1-o0
              if (nin == 2'd1) begin
                ia_r <= i0; ob_r <= o1;
                rem_r <= d_r[i0]; den_r <= d_r[i0] - d_r[o1];
              end else begin
                ia_r <= i1; ob_r <= o0;
                rem_r <= d_r[i1]; den_r <= d_r[i1] - d_r[o0];
              end
              dcnt_r <= '0;
              q_r <= '0;
              st_r <= tpc_pkg::ST_DIV;
            end
          end
        end
        tpc_pkg::ST_EMIT: begin
          if (!ovalid_r || out_ready) begin
            ovalid_r <= 1'b1;
            unique case (list_r[eidx_r])
              3'd3: begin
                odata_r.out_x <= nva_r[0]; odata_r.out_y <= nva_r[1];
                odata_r.out_z <= nva_r[2]; odata_r.out_u <= nva_r[3];
                odata_r.out_v <= nva_r[4];
              end
              3'd4: begin
                odata_r.out_x <= nvb_r[0]; odata_r.out_y <= nvb_r[1];
                odata_r.out_z <= nvb_r[2]; odata_r.out_u <= nvb_r[3];
                odata_r.out_v <= nvb_r[4];
              end
              default: begin
                odata_r.out_x <= pos_r[list_r[eidx_r][1:0]*3];
                odata_r.out_y <= pos_r[list_r[eidx_r][1:0]*3 + 1];
                odata_r.out_z <= pos_r[list_r[eidx_r][1:0]*3 + 2];
                odata_r.out_u <= tex_r[list_r[eidx_r][1:0]*2];
                odata_r.out_v <= tex_r[list_r[eidx_r][1:0]*2 + 1];
              end
            endcase
            odata_r.out_color <= col_r;
            odata_r.tri_end <= (eidx_r == 3'd2) || (eidx_r == 3'd5);
            odata_r.run_end <= (eidx_r == nlist_r - 3'd1);
            eidx_r <= eidx_r + 3'd1;
            if (eidx_r == nlist_r - 3'd1) st_r <= tpc_pkg::ST_LOAD;
          end
        end
        default: st_r <= tpc_pkg::ST_LOAD;
      endcase
    end
  end

endmodule
